>>> hdl/ehd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the energy histogram with dose weighting.
// Used by the controller, datapath, divider, top level and checker.
package ehd_pkg;

    localparam int CMD_W      = 3;
    localparam int ENERGY_W   = 21;
    localparam int SEL_W      = 9;
    localparam int COEFF_W    = 16;
    localparam int SECS_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int HIT_W      = 9;
    localparam int COUNT_W    = 32;
    localparam int DOSE_W     = 63;
    localparam int PROD_W     = COUNT_W + COEFF_W;
    localparam int WIDTH_W    = 10;
    localparam int MAXE_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 6;
    localparam int QBIN_W     = 16;
    localparam int IDX_EXT_W  = 13;

    localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_COEFF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DOSE        = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BEYOND    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO_TIME = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENERGY = 1'd1;

    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET  = 10'd5;
    localparam logic [MAXE_W-1:0]  MAX_ENERGY_RESET = 16'd1500;

    localparam logic [STEP_W-1:0] BIN_DIV_STEPS  = 6'd16;
    localparam logic [STEP_W-1:0] DOSE_DIV_STEPS = 6'd63;

    localparam logic [DOSE_W-1:0] DOSE_SAT = {DOSE_W{1'b1}};

    typedef struct packed {
        logic capture;
        logic sweep_clr;
        logic clr_coeff;
        logic idx_step;
        logic cnt_rd;
        logic rd_quot;
        logic cnt_inc;
        logic coeff_wr;
        logic mac_rd;
        logic div_bin;
        logic div_dose;
        logic load_out;
    } ehd_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             range_bad;
        logic             sel_bad;
        logic             secs_zero;
        logic             bin_bad;
        logic             idx_last;
        logic             div_busy;
        logic             mac_busy;
        logic             sat;
    } ehd_sts_t;

endpackage

>>> hdl/energy_histogram_dose_top.sv
`timescale 1ns / 1ps
// Energy-spectrum histogram with dose weighting: top level.
// Depends on ehd_pkg, ehd_ctrl and ehd_datapath.
//
// One command is worked on at a time; the finished result sits in an output
// register, so the next command is accepted while it waits. After reset the
// block zeroes both memories, one entry a cycle, with item_ready low
// (configuration writes are taken). An add uses the 16-step bit-serial divider
// to find the bin, then a read-modify-write of the count memory. A clear
// sweeps the count memory only; a dose rate runs one bin per cycle through
// the multiply-accumulate, then a 63-step divide unless the sum saturated.
module energy_histogram_dose_top #(
    parameter int NUM_BINS = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [ehd_pkg::CMD_W-1:0]       cmd,
    input  logic signed [ehd_pkg::ENERGY_W-1:0] energy,
    input  logic [ehd_pkg::SEL_W-1:0]       bin_select,
    input  logic [ehd_pkg::COEFF_W-1:0]     coeff_value,
    input  logic [ehd_pkg::SECS_W-1:0]      measure_seconds,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [ehd_pkg::STATUS_W-1:0]    status,
    output logic [ehd_pkg::HIT_W-1:0]       hit_bin,
    output logic [ehd_pkg::COUNT_W-1:0]     bin_count,
    output logic [ehd_pkg::DOSE_W-1:0]      dose_rate,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ehd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ehd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ehd_pkg::*;

    ehd_ctl_t ctl;
    ehd_sts_t sts;
    logic     cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ehd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .ctl          (ctl)
    );

    ehd_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .energy          (energy),
        .bin_select      (bin_select),
        .coeff_value     (coeff_value),
        .measure_seconds (measure_seconds),
        .status          (status),
        .hit_bin         (hit_bin),
        .bin_count       (bin_count),
        .dose_rate       (dose_rate)
    );

endmodule

>>> hdl/ehd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
// Depends on ehd_pkg.
module ehd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ehd_pkg::DOSE_W-1:0]  dividend,
    input  logic [ehd_pkg::SECS_W-1:0]  divisor,
    input  logic [ehd_pkg::STEP_W-1:0]  steps,
    output logic                        busy,
    output logic [ehd_pkg::DOSE_W-1:0]  quotient
);
    import ehd_pkg::*;

    logic                busy_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DOSE_W-1:0]   quo_reg;
    logic [DOSE_W-1:0]   quo_next;
    logic [SECS_W-1:0]   rem_reg;
    logic [SECS_W-1:0]   rem_next;
    logic [SECS_W-1:0]   dvs_reg;
    logic [SECS_W:0]     trial;
    logic [SECS_W:0]     diff;
    logic                ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DOSE_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[SECS_W-1:0] : trial[SECS_W-1:0];
        quo_next = {quo_reg[DOSE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/ehd_datapath.sv
`timescale 1ns / 1ps
// Datapath: transaction registers, count and coefficient memories, MAC, divider, result.
// Depends on ehd_pkg and ehd_div.
module ehd_datapath #(
    parameter int NUM_BINS = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ehd_pkg::ehd_ctl_t               ctl,
    output ehd_pkg::ehd_sts_t               sts,
    input  logic                            cfg_we,
    input  logic [ehd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ehd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [ehd_pkg::CMD_W-1:0]       cmd,
    input  logic [ehd_pkg::ENERGY_W-1:0]    energy,
    input  logic [ehd_pkg::SEL_W-1:0]       bin_select,
    input  logic [ehd_pkg::COEFF_W-1:0]     coeff_value,
    input  logic [ehd_pkg::SECS_W-1:0]      measure_seconds,
    output logic [ehd_pkg::STATUS_W-1:0]    status,
    output logic [ehd_pkg::HIT_W-1:0]       hit_bin,
    output logic [ehd_pkg::COUNT_W-1:0]     bin_count,
    output logic [ehd_pkg::DOSE_W-1:0]      dose_rate
);
    import ehd_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [IDX_EXT_W-1:0] BINS_EXT = IDX_EXT_W'(NUM_BINS);
    localparam logic [QBIN_W:0]      BINS_Q   = (QBIN_W + 1)'(NUM_BINS);
    localparam logic [AW-1:0]        LAST_IDX = AW'(NUM_BINS - 1);

    logic [CMD_W-1:0]    cmd_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [COEFF_W-1:0]  coeff_reg;
    logic [SECS_W-1:0]   secs_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [MAXE_W-1:0]   maxe_reg;
    logic [AW-1:0]       idx_reg;

    logic [COUNT_W-1:0]  cnt_mem [NUM_BINS];
    logic [COEFF_W-1:0]  coef_mem [NUM_BINS];
    logic [COUNT_W-1:0]  cnt_rd_reg;
    logic [COEFF_W-1:0]  coef_rd_reg;

    logic                rdv_reg;
    logic                prodv_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DOSE_W-1:0]   sum_reg;
    logic                sat_reg;
    logic [DOSE_W:0]     acc;

    logic [STATUS_W-1:0] status_reg;
    logic [HIT_W-1:0]    hit_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [DOSE_W-1:0]   dose_reg;
    logic [STATUS_W-1:0] status_next;
    logic [HIT_W-1:0]    hit_next;
    logic [COUNT_W-1:0]  count_next;
    logic [DOSE_W-1:0]   dose_next;

    logic                range_bad;
    logic                sel_bad;
    logic                secs_zero;
    logic                bin_bad;
    logic [WIDTH_W-1:0]  w_eff;
    logic [IDX_EXT_W-1:0] sel_ext;
    logic [AW-1:0]       s_idx;
    logic [QBIN_W-1:0]   q_bin;
    logic [AW-1:0]       q_idx;

    logic                cnt_we;
    logic [AW-1:0]       cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic                cnt_re;
    logic [AW-1:0]       cnt_raddr;
    logic                coef_we;
    logic [AW-1:0]       coef_waddr;
    logic [COEFF_W-1:0]  coef_wdata;
    logic [COUNT_W-1:0]  cnt_inc_val;

    logic                div_start;
    logic [DOSE_W-1:0]   div_dividend;
    logic [SECS_W-1:0]   div_divisor;
    logic [STEP_W-1:0]   div_steps;
    logic                div_busy;
    logic [DOSE_W-1:0]   quotient;

    ehd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg    <= cmd;
            energy_reg <= energy;
            sel_reg    <= bin_select;
            coeff_reg  <= coeff_value;
            secs_reg   <= measure_seconds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= BIN_WIDTH_RESET;
            maxe_reg  <= MAX_ENERGY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIN_WIDTH:  width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_MAX_ENERGY: maxe_reg  <= cfg_data[MAXE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctl.idx_step)
        begin
            idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        range_bad = energy_reg[ENERGY_W-1]
                    || (energy_reg[ENERGY_W-2:0] >= {maxe_reg, 4'b0000});
        w_eff     = (width_reg == '0) ? WIDTH_W'(1) : width_reg;
        sel_ext   = IDX_EXT_W'(sel_reg);
        sel_bad   = (sel_ext >= BINS_EXT);
        s_idx     = sel_ext[AW-1:0];
        secs_zero = (secs_reg == '0);
        q_bin     = quotient[QBIN_W-1:0];
        bin_bad   = ({1'b0, q_bin} >= BINS_Q);
        q_idx     = q_bin[AW-1:0];
    end

    always_comb
    begin
        cnt_inc_val = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
        cnt_we      = ctl.sweep_clr || ctl.cnt_inc;
        cnt_waddr   = ctl.sweep_clr ? idx_reg : q_idx;
        cnt_wdata   = ctl.sweep_clr ? '0 : cnt_inc_val;
        cnt_re      = ctl.cnt_rd || ctl.mac_rd;
        cnt_raddr   = ctl.mac_rd ? idx_reg : (ctl.rd_quot ? q_idx : s_idx);
        coef_we     = (ctl.sweep_clr && ctl.clr_coeff) || ctl.coeff_wr;
        coef_waddr  = ctl.coeff_wr ? s_idx : idx_reg;
        coef_wdata  = ctl.coeff_wr ? coeff_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (ctl.mac_rd)
        begin
            coef_rd_reg <= coef_mem[idx_reg];
        end
    end

    assign acc = {1'b0, sum_reg} + (DOSE_W + 1)'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg   <= 1'b0;
            prodv_reg <= 1'b0;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            rdv_reg   <= ctl.mac_rd;
            prodv_reg <= rdv_reg;
            if (ctl.capture)
            begin
                sum_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (prodv_reg)
            begin
                sum_reg <= acc[DOSE_W-1:0];
                sat_reg <= sat_reg || acc[DOSE_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            prod_reg <= cnt_rd_reg * coef_rd_reg;
        end
    end

    always_comb
    begin
        div_start    = ctl.div_bin || ctl.div_dose;
        div_dividend = ctl.div_bin
                       ? {energy_reg[ENERGY_W-2:4], {(DOSE_W - QBIN_W){1'b0}}}
                       : sum_reg;
        div_divisor  = ctl.div_bin ? SECS_W'(w_eff) : secs_reg;
        div_steps    = ctl.div_bin ? BIN_DIV_STEPS : DOSE_DIV_STEPS;
    end

    always_comb
    begin
        status_next = STS_OK;
        hit_next    = '0;
        count_next  = '0;
        dose_next   = '0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (range_bad)
                begin
                    status_next = STS_RANGE;
                end
                else if (bin_bad)
                begin
                    status_next = STS_BEYOND;
                end
                else
                begin
                    hit_next = q_bin[HIT_W-1:0];
                end
            end
            CMD_READ:
            begin
                if (sel_bad)
                begin
                    status_next = STS_BEYOND;
                end
                else
                begin
                    count_next = cnt_rd_reg;
                end
            end
            CMD_WRITE_COEFF:
            begin
                if (sel_bad)
                begin
                    status_next = STS_BEYOND;
                end
            end
            CMD_DOSE:
            begin
                if (secs_zero)
                begin
                    status_next = STS_ZERO_TIME;
                end
                else
                begin
                    dose_next = sat_reg ? DOSE_SAT : quotient;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            count_reg  <= count_next;
            dose_reg   <= dose_next;
        end
    end

    assign status    = status_reg;
    assign hit_bin   = hit_reg;
    assign bin_count = count_reg;
    assign dose_rate = dose_reg;

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.range_bad = range_bad;
        sts.sel_bad   = sel_bad;
        sts.secs_zero = secs_zero;
        sts.bin_bad   = bin_bad;
        sts.idx_last  = (idx_reg == LAST_IDX);
        sts.div_busy  = div_busy;
        sts.mac_busy  = rdv_reg || prodv_reg;
        sts.sat       = sat_reg;
    end

endmodule

>>> hdl/ehd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences sweeps, divides and memory accesses.
// Depends on ehd_pkg.
module ehd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  ehd_pkg::ehd_sts_t  sts,
    output ehd_pkg::ehd_ctl_t  ctl
);
    import ehd_pkg::*;

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DECODE   = 4'd2;
    localparam logic [3:0] ST_CLR      = 4'd3;
    localparam logic [3:0] ST_DIV      = 4'd4;
    localparam logic [3:0] ST_INC      = 4'd5;
    localparam logic [3:0] ST_MAC      = 4'd6;
    localparam logic [3:0] ST_MAC_WAIT = 4'd7;
    localparam logic [3:0] ST_DDIV     = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rv_reg;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = rv_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                ctl.sweep_clr = 1'b1;
                ctl.clr_coeff = 1'b1;
                ctl.idx_step  = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.cmd)
                    CMD_ADD:
                    begin
                        if (sts.range_bad)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            ctl.div_bin = 1'b1;
                            state_next  = ST_DIV;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_CLR;
                    end
                    CMD_READ:
                    begin
                        ctl.cnt_rd = !sts.sel_bad;
                        state_next = ST_FINISH;
                    end
                    CMD_WRITE_COEFF:
                    begin
                        ctl.coeff_wr = !sts.sel_bad;
                        state_next   = ST_FINISH;
                    end
                    CMD_DOSE:
                    begin
                        state_next = sts.secs_zero ? ST_FINISH : ST_MAC;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_CLR:
            begin
                ctl.sweep_clr = 1'b1;
                ctl.idx_step  = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.bin_bad)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ctl.cnt_rd  = 1'b1;
                        ctl.rd_quot = 1'b1;
                        state_next  = ST_INC;
                    end
                end
            end
            ST_INC:
            begin
                ctl.cnt_inc = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_MAC:
            begin
                ctl.mac_rd   = 1'b1;
                ctl.idx_step = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT:
            begin
                if (!sts.mac_busy)
                begin
                    if (sts.sat)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ctl.div_dose = 1'b1;
                        state_next   = ST_DDIV;
                    end
                end
            end
            ST_DDIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rv_reg || result_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load_out)
            begin
                rv_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/ehd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the energy histogram top level, with its bind.
// Depends on ehd_pkg and energy_histogram_dose_top.
module ehd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [ehd_pkg::STATUS_W-1:0]  status,
    input logic [ehd_pkg::HIT_W-1:0]     hit_bin,
    input logic [ehd_pkg::COUNT_W-1:0]   bin_count,
    input logic [ehd_pkg::DOSE_W-1:0]    dose_rate
);
    import ehd_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transaction completed");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(status) && $stable(hit_bin)
            && $stable(bin_count) && $stable(dose_rate))
        else $error("result payload changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != STS_OK) |->
            (hit_bin == '0) && (bin_count == '0) && (dose_rate == '0))
        else $error("error result carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("new transaction accepted while one is in progress");

endmodule

bind energy_histogram_dose_top ehd_checker u_ehd_checker (.*);

>>> test/energy_histogram_dose_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for energy_histogram_dose_top: a directed command table, then
// random command phases under several bin settings, scored against a local histogram model.
// Depends on ehd_pkg and the RTL of energy_histogram_dose_top.
module energy_histogram_dose_top_tb;
    import ehd_pkg::*;

    localparam int NUM_BINS        = 512;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int NUM_PHASES      = 8;
    localparam int STEADY_PHASE    = 3;
    localparam int DRAIN_CYCLES    = NUM_BINS + 100;
    localparam int IDLE_PCT        = 32;

    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
    localparam longint DOSE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    hit_bin;
        logic [COUNT_W-1:0]  bin_count;
        logic [DOSE_W-1:0]   dose_rate;
    } spectrum_result_t;

    typedef enum {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_e;

    // register rows carry the register index in sel and the write data in cv
    typedef struct {
        row_kind_e        kind;
        logic [CMD_W-1:0] op;
        int               ev;
        int               sel;
        int               cv;
        int               secs;
        spectrum_result_t want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic [CMD_W-1:0]           cmd = '0;
    logic signed [ENERGY_W-1:0] energy = '0;
    logic [SEL_W-1:0]           bin_select = '0;
    logic [COEFF_W-1:0]         coeff_value = '0;
    logic [SECS_W-1:0]          measure_seconds = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic [HIT_W-1:0]           hit_bin;
    logic [COUNT_W-1:0]         bin_count;
    logic [DOSE_W-1:0]          dose_rate;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    logic [COUNT_W-1:0] counts_mem [NUM_BINS];
    logic [COEFF_W-1:0] coeff_mem [NUM_BINS];
    logic [WIDTH_W-1:0] width_kev_reg;
    logic [MAXE_W-1:0]  max_kev_reg;

    spectrum_result_t pending_results [$];
    int n_fail = 0;
    bit steady = 1'b0;

    energy_histogram_dose_top #(
        .NUM_BINS(NUM_BINS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .cmd(cmd),
        .energy(energy),
        .bin_select(bin_select),
        .coeff_value(coeff_value),
        .measure_seconds(measure_seconds),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .status(status),
        .hit_bin(hit_bin),
        .bin_count(bin_count),
        .dose_rate(dose_rate),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(80_000_000);
        $display("FAIL energy_histogram_dose_top");
        $finish;
    end

    function automatic spectrum_result_t apply_command(logic [CMD_W-1:0] op, longint ev,
                                                      int sel, logic [COEFF_W-1:0] cv,
                                                      longint secs);
        spectrum_result_t r;
        longint span;
        longint idx;
        longint acc;
        longint prod;
        bit sat;
        r = '0;
        case (op)
            CMD_ADD:
            begin
                span = (width_kev_reg == 0) ? 16 : 16 * longint'(width_kev_reg);
                if (ev < 0 || ev >= 16 * longint'(max_kev_reg))
                begin
                    r.status = STS_RANGE;
                end
                else
                begin
                    idx = ev / span;
                    if (idx >= NUM_BINS)
                    begin
                        r.status = STS_BEYOND;
                    end
                    else
                    begin
                        if (counts_mem[idx] != '1)
                            counts_mem[idx] = counts_mem[idx] + 1'b1;
                        r.hit_bin = idx[HIT_W-1:0];
                    end
                end
            end
            CMD_CLEAR:
            begin
                foreach (counts_mem[i])
                    counts_mem[i] = '0;
            end
            CMD_READ:
            begin
                if (sel >= NUM_BINS)
                    r.status = STS_BEYOND;
                else
                    r.bin_count = counts_mem[sel];
            end
            CMD_WRITE_COEFF:
            begin
                if (sel >= NUM_BINS)
                    r.status = STS_BEYOND;
                else
                    coeff_mem[sel] = cv;
            end
            CMD_DOSE:
            begin
                if (secs == 0)
                begin
                    r.status = STS_ZERO_TIME;
                end
                else
                begin
                    acc = 0;
                    sat = 1'b0;
                    for (int i = 0; i < NUM_BINS; i++)
                    begin
                        prod = longint'(counts_mem[i]) * longint'(coeff_mem[i]);
                        if (!sat && prod > DOSE_LIMIT - acc)
                            sat = 1'b1;
                        else if (!sat)
                            acc = acc + prod;
                    end
                    r.dose_rate = sat ? DOSE_SAT : DOSE_W'(acc / secs);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [CMD_W-1:0] op, int ev, int sel, int cv,
                                           int secs);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.op = op;
        r.ev = ev;
        r.sel = sel;
        r.cv = cv;
        r.secs = secs;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic [CMD_W-1:0] op, int ev, int sel, int cv,
                                              int secs, logic [STATUS_W-1:0] st, int hit,
                                              longint cnt);
        stim_row_t r;
        r = item_row(op, ev, sel, cv, secs);
        r.kind = ROW_CHECKED;
        r.want.status = st;
        r.want.hit_bin = hit[HIT_W-1:0];
        r.want.bin_count = cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
        stim_row_t r;
        r = item_row(CMD_ADD, 0, idx, data, 0);
        r.kind = ROW_CFG;
        return r;
    endfunction

    function automatic void enqueue_result(input spectrum_result_t r);
        pending_results = {pending_results, r};
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] op, input logic signed [ENERGY_W-1:0] ev,
                             input logic [SEL_W-1:0] sel, input logic [COEFF_W-1:0] cv,
                             input logic [SECS_W-1:0] secs, input bit typed,
                             input spectrum_result_t want);
        spectrum_result_t pred;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        cmd             <= op;
        energy          <= ev;
        bin_select      <= sel;
        coeff_value     <= cv;
        measure_seconds <= secs;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pred = apply_command(op, ev, sel, cv, secs);
        enqueue_result(typed ? want : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BIN_WIDTH)
            width_kev_reg = data[WIDTH_W-1:0];
        else
            max_kev_reg = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_row(input stim_row_t row);
        case (row.kind)
            ROW_CFG:
            begin
                drain_results();
                write_reg(row.sel[CFG_IDX_W-1:0], row.cv[CFG_DATA_W-1:0]);
            end
            default:
            begin
                send_item(row.op, row.ev[ENERGY_W-1:0], row.sel[SEL_W-1:0],
                          row.cv[COEFF_W-1:0], row.secs[SECS_W-1:0],
                          row.kind == ROW_CHECKED, row.want);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : score_results
        spectrum_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no pending transaction, status %0d", status);
                n_fail++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_fail++;
                end
                if (hit_bin !== want.hit_bin)
                begin
                    $error("hit_bin: expected %0d, got %0d", want.hit_bin, hit_bin);
                    n_fail++;
                end
                if (bin_count !== want.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d", want.bin_count, bin_count);
                    n_fail++;
                end
                if (dose_rate !== want.dose_rate)
                begin
                    $error("dose_rate: expected %0d, got %0d", want.dose_rate, dose_rate);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t directed [$];
        int done;
        int pick;
        int lim;
        int span;
        logic [CMD_W-1:0] op;
        logic signed [ENERGY_W-1:0] ev;
        logic [SEL_W-1:0] sel;
        logic [COEFF_W-1:0] cv;
        logic [SECS_W-1:0] secs;
        logic [CFG_DATA_W-1:0] width_data;
        logic [CFG_DATA_W-1:0] max_data;
        spectrum_result_t none;

        none = '0;
        width_kev_reg = BIN_WIDTH_RESET;
        max_kev_reg = MAX_ENERGY_RESET;
        foreach (counts_mem[i])
        begin
            counts_mem[i] = '0;
            coeff_mem[i] = '0;
        end

        directed = '{
            checked_row(CMD_READ, 0, 0, 0, 0, STS_OK, 0, 0),
            checked_row(CMD_DOSE, 0, 0, 0, 1, STS_OK, 0, 0),
            checked_row(CMD_DOSE, 0, 0, 0, 0, STS_ZERO_TIME, 0, 0),
            checked_row(CMD_ADD, -1, 0, 0, 0, STS_RANGE, 0, 0),
            checked_row(CMD_ADD, -1048576, 0, 0, 0, STS_RANGE, 0, 0),
            checked_row(CMD_ADD, 1048575, 0, 0, 0, STS_RANGE, 0, 0),
            checked_row(CMD_ADD, 0, 0, 0, 0, STS_OK, 0, 0),
            checked_row(CMD_ADD, 23999, 0, 0, 0, STS_OK, 299, 0),
            checked_row(CMD_ADD, 24000, 0, 0, 0, STS_RANGE, 0, 0),
            checked_row(CMD_WRITE_COEFF, 0, 0, 16'hFFFF, 0, STS_OK, 0, 0),
            checked_row(CMD_WRITE_COEFF, 0, 299, 16'h1000, 0, STS_OK, 0, 0),
            checked_row(CMD_WRITE_COEFF, 0, 511, 16'h8001, 0, STS_OK, 0, 0),
            item_row(CMD_READ, 0, 0, 0, 0),
            item_row(CMD_DOSE, 0, 0, 0, 16'hFFFF),
            item_row(CMD_DOSE, 0, 0, 0, 1),
            checked_row(CMD_RSVD_FIRST, -1, 511, 16'hFFFF, 16'hFFFF, STS_OK, 0, 0),
            checked_row(CMD_RSVD_LAST, -1048576, 0, 0, 0, STS_OK, 0, 0),
            checked_row(CMD_CLEAR, 0, 0, 0, 0, STS_OK, 0, 0),
            checked_row(CMD_READ, 0, 0, 0, 0, STS_OK, 0, 0),
            cfg_row(CFG_MAX_ENERGY, 16'hFFFF),
            cfg_row(CFG_BIN_WIDTH, 1),
            checked_row(CMD_ADD, 1048559, 0, 0, 0, STS_BEYOND, 0, 0),
            checked_row(CMD_ADD, 8191, 0, 0, 0, STS_OK, 511, 0),
            checked_row(CMD_ADD, 8192, 0, 0, 0, STS_BEYOND, 0, 0),
            cfg_row(CFG_BIN_WIDTH, 0),
            item_row(CMD_ADD, 16, 0, 0, 0),
            cfg_row(CFG_BIN_WIDTH, 1023),
            cfg_row(CFG_MAX_ENERGY, 0),
            checked_row(CMD_ADD, 0, 0, 0, 0, STS_RANGE, 0, 0),
            item_row(CMD_READ, 0, 511, 0, 0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
            run_row(directed[k]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    width_data = BIN_WIDTH_RESET;
                    max_data = MAX_ENERGY_RESET;
                end
                1:
                begin
                    width_data = 16'd1;
                    max_data = 16'hFFFF;
                end
                2:
                begin
                    width_data = 16'd1023;
                    max_data = 16'hFFFF;
                end
                3:
                begin
                    width_data = 16'd3;
                    max_data = 16'd1536;
                end
                4:
                begin
                    width_data = 16'd1;
                    max_data = 16'd1;
                end
                5:
                begin
                    width_data = $urandom_range(0, 16'hFFFF);
                    max_data = $urandom_range(1, 16'hFFFF);
                end
                6:
                begin
                    width_data = $urandom_range(1, 1023);
                    max_data = $urandom_range(1, 16'hFFFF);
                end
                default:
                begin
                    width_data = 16'h0400;
                    max_data = 16'd600;
                end
            endcase
            write_reg(CFG_BIN_WIDTH, width_data);
            write_reg(CFG_MAX_ENERGY, max_data);
            steady = (p == STEADY_PHASE);
            lim = 16 * int'(max_kev_reg);
            span = 16 * ((width_kev_reg == 0) ? 1 : int'(width_kev_reg));

            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    op = CMD_ADD;
                else if (pick < 74)
                    op = CMD_READ;
                else if (pick < 85)
                    op = CMD_WRITE_COEFF;
                else if (pick < 91)
                    op = CMD_DOSE;
                else if (pick < 93)
                    op = CMD_CLEAR;
                else
                    op = $urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST);

                pick = $urandom_range(0, 99);
                if (pick < 50)
                    ev = $urandom_range(0, ((lim < 4096) ? lim : 4096) - 1);
                else if (pick < 75)
                    ev = $urandom_range(0, lim - 1);
                else if (pick < 85)
                    ev = span * $urandom_range(0, lim / span + 1) - $urandom_range(0, 1);
                else if (pick < 90)
                    ev = lim - $urandom_range(0, 1);
                else if (pick < 95)
                    ev = -int'($urandom_range(1, 1048576));
                else
                    ev = $urandom();

                if ($urandom_range(0, 1) == 1)
                    sel = $urandom_range(0, 31);
                else
                    sel = $urandom_range(0, NUM_BINS - 1);
                cv = ($urandom_range(0, 9) == 0) ? '1 : $urandom();

                pick = $urandom_range(0, 99);
                if (pick < 6)
                    secs = '0;
                else if (pick < 20)
                    secs = 16'd1;
                else if (pick < 50)
                    secs = $urandom_range(1, 255);
                else
                    secs = $urandom_range(1, 16'hFFFF);

                send_item(op, ev, sel, cv, secs, 1'b0, none);
                done++;
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("PASS energy_histogram_dose_top");
        else
            $display("FAIL energy_histogram_dose_top");
        $finish;
    end

endmodule
